### sv/rgb_sharpen_filter_3x3_macros.svh
// ----------------------------------------------------------------------------
// rgb_sharpen_filter_3x3 assertion macros
// Concurrent assertion wrappers clocked on clk_i; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RGB_SHARPEN_FILTER_3X3_MACROS_SVH
`define RGB_SHARPEN_FILTER_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define RSF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define RSF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define RSF_ASSERT(name, prop, msg)
`define RSF_ASSERT_RST(name, prop, msg)

`endif

`endif

### sv/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Word types and constants of the RGB 3x3 sharpening filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsf_pkg;

  localparam logic [7:0] AmountReset = 8'd16;

  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] mid_red;
    logic [7:0] mid_green;
    logic [7:0] mid_blue;
    logic [7:0] bot_red;
    logic [7:0] bot_green;
    logic [7:0] bot_blue;
    logic       row_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_row_end;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one column of the window: rows above, current, below
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

endpackage

`default_nettype wire

### sv/rsf_in_if.sv
// ----------------------------------------------------------------------------
// rsf_in_if
// Pixel column channel: valid/ready handshake with a pix_in_t word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsf_in_if;
  import rsf_pkg::*;

  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rsf_out_if.sv
// ----------------------------------------------------------------------------
// rsf_out_if
// Filtered pixel channel: valid/ready handshake with a pix_out_t word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsf_out_if;
  import rsf_pkg::*;

  logic     valid;
  logic     ready;
  pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rsf_cfg_if.sv
// ----------------------------------------------------------------------------
// rsf_cfg_if
// Configuration write channel carrying the sharpening amount.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rgb_sharpen_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_sharpen_filter_3x3
// 3x3 sharpening filter over an RGB888 column stream with border replication.
// ----------------------------------------------------------------------------
// Takes one pixel column (above/current/below) per word, left to right, and
// returns one sharpened pixel per column of the row: kernel corners -a, edges
// -2a, center 16+12a with a = amount, result /16 clamped to 0..255, edge
// columns replicated at both borders. The first column of a row gives no word
// unless it ends the row; each later column gives the pixel before it, and the
// row_end column also gives its own pixel with out_row_end set. A column is
// accepted every cycle unless the output stalls; a row_end column after other
// columns of its row holds the filter stage for both its words, since the
// single per-channel multiplier path produces one pixel per cycle, so the input
// also stalls on such rows. amount resets to 16 and is written through cfg_i;
// the user must write it only while the block is idle; it is not enforced.
`default_nettype none
`include "rgb_sharpen_filter_3x3_macros.svh"

module rgb_sharpen_filter_3x3 (
  input  logic   clk_i,
  input  logic   rst_ni,
  rsf_in_if.sink   pix_i,
  rsf_out_if.source pix_o,
  rsf_cfg_if.sink  cfg_i
);
  import rsf_pkg::*;

  logic [7:0] amount_q;

  // window: two previous columns of the current row
  col_t       older_q, newer_q;
  logic [1:0] held_q;

  // filter stage input register
  logic       s1_vld_q;
  logic       s1_ph_q;   // second word of a row_end column
  logic       s1_two_q;  // column gives two words
  logic       s1_end0_q; // first word closes the row (single-column row)
  col_t       s1_l_q, s1_c_q, s1_r_q;

  // output register
  logic       out_vld_q;
  pix_out_t   out_q;

  logic       in_acc, s1_load, s1_move, s1_done;
  col_t       cur;
  col_t       sel_l, sel_c, sel_r;
  logic       sel_end;
  pix_out_t   res;

  function automatic logic [9:0] sum4(logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c, logic [7:0] d);
    sum4 = ({2'b0, a} + {2'b0, b}) + ({2'b0, c} + {2'b0, d});
  endfunction

  function automatic logic [7:0] sharpen(logic [7:0] ctr, logic [9:0] corners,
                                         logic [9:0] edges, logic [7:0] amt);
    logic        [12:0] c12;
    logic        [12:0] neg;
    logic signed [12:0] inner;
    logic signed [21:0] prod;
    logic signed [21:0] sum;
    c12   = {2'b0, ctr, 3'b0} + {3'b0, ctr, 2'b0};
    neg   = {3'b0, corners} + {2'b0, edges, 1'b0};
    inner = $signed(c12) - $signed(neg);
    prod  = inner * $signed({1'b0, amt});
    sum   = prod + $signed({10'b0, ctr, 4'b0});
    // any negative sum truncates to a value <= 0 and clamps to zero
    if (sum[21]) begin
      sharpen = 8'd0;
    end else if (|sum[20:12]) begin
      sharpen = 8'd255;
    end else begin
      sharpen = sum[11:4];
    end
  endfunction

  assign cur.top = '{red: pix_i.data.top_red, green: pix_i.data.top_green,
                     blue: pix_i.data.top_blue};
  assign cur.mid = '{red: pix_i.data.mid_red, green: pix_i.data.mid_green,
                     blue: pix_i.data.mid_blue};
  assign cur.bot = '{red: pix_i.data.bot_red, green: pix_i.data.bot_green,
                     blue: pix_i.data.bot_blue};

  assign s1_move     = s1_vld_q && (!out_vld_q || pix_o.ready);
  assign s1_done     = s1_move && (!s1_two_q || s1_ph_q);
  assign pix_i.ready = !s1_vld_q || s1_done;
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign s1_load     = in_acc && ((held_q != 2'd0) || pix_i.data.row_end);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= AmountReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      amount_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      held_q  <= 2'd0;
    end else if (in_acc) begin
      if (held_q == 2'd0) begin
        if (!pix_i.data.row_end) begin
          newer_q <= cur;
          held_q  <= 2'd1;
        end
      end else if (pix_i.data.row_end) begin
        held_q <= 2'd0;
      end else begin
        older_q <= newer_q;
        newer_q <= cur;
        held_q  <= 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_ph_q  <= 1'b0;
    end else if (s1_load) begin
      s1_vld_q <= 1'b1;
      s1_ph_q  <= 1'b0;
    end else if (s1_done) begin
      s1_vld_q <= 1'b0;
      s1_ph_q  <= 1'b0;
    end else if (s1_move) begin
      s1_ph_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_two_q  <= (held_q != 2'd0) && pix_i.data.row_end;
      s1_end0_q <= held_q == 2'd0;
      s1_l_q    <= (held_q == 2'd0) ? cur : ((held_q == 2'd1) ? newer_q : older_q);
      s1_c_q    <= (held_q == 2'd0) ? cur : newer_q;
      s1_r_q    <= cur;
    end
  end

  // second word of a row_end column: newer column left, current as center
  // and replicated right border
  always_comb begin
    if (s1_ph_q) begin
      sel_l   = s1_c_q;
      sel_c   = s1_r_q;
      sel_r   = s1_r_q;
      sel_end = 1'b1;
    end else begin
      sel_l   = s1_l_q;
      sel_c   = s1_c_q;
      sel_r   = s1_r_q;
      sel_end = s1_end0_q;
    end
    res.out_red = sharpen(sel_c.mid.red,
        sum4(sel_l.top.red, sel_r.top.red, sel_l.bot.red, sel_r.bot.red),
        sum4(sel_c.top.red, sel_c.bot.red, sel_l.mid.red, sel_r.mid.red),
        amount_q);
    res.out_green = sharpen(sel_c.mid.green,
        sum4(sel_l.top.green, sel_r.top.green, sel_l.bot.green, sel_r.bot.green),
        sum4(sel_c.top.green, sel_c.bot.green, sel_l.mid.green, sel_r.mid.green),
        amount_q);
    res.out_blue = sharpen(sel_c.mid.blue,
        sum4(sel_l.top.blue, sel_r.top.blue, sel_l.bot.blue, sel_r.bot.blue),
        sum4(sel_c.top.blue, sel_c.bot.blue, sel_l.mid.blue, sel_r.mid.blue),
        amount_q);
    res.out_row_end = sel_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_move) begin
      out_vld_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res;
    end
  end

  assign pix_o.valid = out_vld_q;
  assign pix_o.data  = out_q;

  `RSF_ASSERT(a_phase_two, s1_vld_q && s1_ph_q |-> s1_two_q, "second word without row end")
  `RSF_ASSERT(a_row_end_clr, in_acc && pix_i.data.row_end |=> held_q == 2'd0, "row end kept columns")
  `RSF_ASSERT(a_stall_busy, !pix_i.ready |-> s1_vld_q, "input stalled with empty filter stage")
  `RSF_ASSERT(a_out_src, $rose(pix_o.valid) |-> $past(s1_vld_q), "output word without source")
  `RSF_ASSERT_RST(a_rst_quiet, !rst_ni |=> !pix_o.valid && pix_i.ready, "not quiet in reset")

endmodule

`default_nettype wire

### test/rsf_sharpen_checker.sv
// ----------------------------------------------------------------------------
// rsf_sharpen_checker
// Watches the column, pixel and amount channels of the sharpening filter,
// predicts every output word from the accepted columns and compares them.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_sharpen_checker
  import rsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rsf_in_if    pix_i,
  rsf_out_if   pix_o,
  rsf_cfg_if   cfg_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  logic [7:0] amount_q;
  col_t       win_old;
  col_t       win_new;
  logic [1:0] cols_held;
  pix_out_t   exp_px_q[$];
  int         fail_cnt = 0;

  function automatic int chan(rgb_t p, int sh);
    return int'((p >> sh) & 24'hff);
  endfunction

  function automatic logic [7:0] sharpen_chan(col_t l, col_t c, col_t r, int sh);
    int a;
    int corners;
    int edges;
    int acc;
    a = int'(amount_q);
    corners = chan(l.top, sh) + chan(r.top, sh) + chan(l.bot, sh) + chan(r.bot, sh);
    edges = chan(c.top, sh) + chan(c.bot, sh) + chan(l.mid, sh) + chan(r.mid, sh);
    acc = chan(c.mid, sh) * (16 + 12 * a) - corners * a - edges * 2 * a;
    acc = acc / 16;  // truncates toward zero
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function automatic pix_out_t sharpen_px(col_t l, col_t c, col_t r, logic last);
    pix_out_t px;
    px.out_red     = sharpen_chan(l, c, r, 16);
    px.out_green   = sharpen_chan(l, c, r, 8);
    px.out_blue    = sharpen_chan(l, c, r, 0);
    px.out_row_end = last;
    return px;
  endfunction

  // one column in: words for the previous column and, on row end, this one
  function automatic void predict_col(pix_in_t w);
    col_t cur;
    cur.top = {w.top_red, w.top_green, w.top_blue};
    cur.mid = {w.mid_red, w.mid_green, w.mid_blue};
    cur.bot = {w.bot_red, w.bot_green, w.bot_blue};
    if (cols_held == 2'd0) begin
      if (w.row_end) begin
        exp_px_q.push_back(sharpen_px(cur, cur, cur, 1'b1));
      end else begin
        win_new = cur;
        cols_held = 2'd1;
      end
    end else begin
      // left border replicates the first column
      exp_px_q.push_back(sharpen_px(cols_held == 2'd1 ? win_new : win_old,
                                    win_new, cur, 1'b0));
      if (w.row_end) begin
        exp_px_q.push_back(sharpen_px(win_new, cur, cur, 1'b1));
        cols_held = 2'd0;
      end else begin
        win_old = win_new;
        win_new = cur;
        cols_held = 2'd2;
      end
    end
  endfunction

  function automatic void check_px(pix_out_t got);
    pix_out_t want;
    if (exp_px_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("unexpected word: r=%0d g=%0d b=%0d end=%0b",
                 got.out_red, got.out_green, got.out_blue, got.out_row_end);
      return;
    end
    want = exp_px_q.pop_front();
    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
        got.out_blue !== want.out_blue || got.out_row_end !== want.out_row_end) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch: want r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                 want.out_red, want.out_green, want.out_blue, want.out_row_end,
                 got.out_red, got.out_green, got.out_blue, got.out_row_end);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q = AmountReset;
      win_old = '0;
      win_new = '0;
      cols_held = 2'd0;
      exp_px_q.delete();
    end else begin
      if (pix_o.valid && pix_o.ready) check_px(pix_o.data);
      if (cfg_i.valid && cfg_i.ready) amount_q = cfg_i.data;
      if (pix_i.valid && pix_i.ready) predict_col(pix_i.data);
    end
    fail_cnt_o <= fail_cnt;
    pending_o <= exp_px_q.size();
  end

endmodule

`default_nettype wire

### test/tb_rgb_sharpen_filter_3x3.sv
// ----------------------------------------------------------------------------
// tb_rgb_sharpen_filter_3x3
// Drives pixel columns and amount writes into the sharpening filter with
// bursty input and a stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_sharpen_filter_3x3;
  import rsf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int ItemsRandom = 700;
  localparam int NumPhases   = 8;
  localparam int DrainCycles = 8;

  typedef enum {RdyAlways, RdyMostly, RdyPeriodic, RdyCoin} rdy_mode_e;
  typedef enum {RowNoise, RowSmooth, RowExtreme, RowFlatMid} row_style_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      sink_ready = 1'b0;
  int        fail_cnt;
  int        pending;
  int        cycle_cnt = 0;
  int        burst_left = 0;
  int        cols_sent = 0;
  logic      allow_gaps = 1'b1;
  rdy_mode_e rdy_mode = RdyAlways;
  int        rdy_tick = 0;

  rsf_in_if  pix_if ();
  rsf_out_if out_if ();
  rsf_cfg_if cfg_if ();

  assign out_if.ready = sink_ready;

  rgb_sharpen_filter_3x3 u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .pix_o  (out_if),
    .cfg_i  (cfg_if)
  );

  rsf_sharpen_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .pix_o      (out_if),
    .cfg_i      (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("rgb_sharpen_filter_3x3 regression: fail");
      $finish;
    end
  end

  // receiver: switches at random between stall patterns
  always @(posedge clk_i) begin
    rdy_tick++;
    if (rdy_tick % 200 == 0) rdy_mode = rdy_mode_e'($urandom_range(0, 3));
    case (rdy_mode)
      RdyAlways:   sink_ready <= 1'b1;
      RdyMostly:   sink_ready <= ($urandom_range(0, 3) != 0);
      RdyPeriodic: sink_ready <= ((rdy_tick % 7) < 4);
      default:     sink_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic send_col(input pix_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (allow_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.data <= w;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    cols_sent++;
  endtask

  // hold the input until every expected word is out, then let the pipe settle
  task automatic drain();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_amount(input logic [7:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic pix_in_t flat_col(logic [7:0] v, logic last);
    pix_in_t w;
    w = {{9{v}}, last};
    return w;
  endfunction

  function automatic pix_in_t band_col(logic [7:0] t, logic [7:0] m, logic [7:0] b,
                                       logic last);
    pix_in_t w;
    w = {{3{t}}, {3{m}}, {3{b}}, last};
    return w;
  endfunction

  function automatic logic [7:0] pick_byte(row_style_e style, int base);
    int v;
    case (style)
      RowSmooth: begin
        v = base + int'($urandom_range(0, 24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
      end
      RowExtreme: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      RowFlatMid: return $urandom_range(0, 1) ? base[7:0] : 8'($urandom);
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic send_rand_row(input int len);
    pix_in_t    w;
    row_style_e style;
    int         base;
    style = row_style_e'($urandom_range(0, 3));
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      w.top_red   = pick_byte(style, base);
      w.top_green = pick_byte(style, base);
      w.top_blue  = pick_byte(style, base);
      w.mid_red   = pick_byte(style, base);
      w.mid_green = pick_byte(style, base);
      w.mid_blue  = pick_byte(style, base);
      w.bot_red   = pick_byte(style, base);
      w.bot_green = pick_byte(style, base);
      w.bot_blue  = pick_byte(style, base);
      w.row_end   = (i == len - 1);
      send_col(w);
    end
  endtask

  initial begin
    logic [7:0] amt;
    int         row_len;
    int         phase_end;

    pix_if.valid <= 1'b0;
    pix_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-column rows at both extremes
    send_col(flat_col(8'hff, 1'b1));
    send_col(flat_col(8'h00, 1'b1));
    // bright center on dark ground saturates high, dark center on bright low
    send_col(flat_col(8'h00, 1'b0));
    send_col(flat_col(8'hff, 1'b0));
    send_col(flat_col(8'h00, 1'b1));
    send_col(flat_col(8'hff, 1'b0));
    send_col(flat_col(8'h00, 1'b0));
    send_col(flat_col(8'hff, 1'b1));
    // two-column row
    send_col(flat_col(8'h80, 1'b0));
    send_col(band_col(8'h11, 8'h99, 8'hee, 1'b1));
    // alternating bit patterns
    send_col(band_col(8'haa, 8'h55, 8'haa, 1'b0));
    send_col(band_col(8'h55, 8'haa, 8'h55, 1'b0));
    send_col(band_col(8'haa, 8'h55, 8'haa, 1'b0));
    send_col(band_col(8'h55, 8'haa, 8'h55, 1'b1));

    // zero amount passes the center through
    set_amount(8'd0);
    send_col(band_col(8'h00, 8'h7f, 8'hff, 1'b0));
    send_col(band_col(8'hff, 8'h01, 8'h00, 1'b0));
    send_col(band_col(8'h3c, 8'hc3, 8'h3c, 1'b1));
    // strongest amount
    set_amount(8'd255);
    send_col(band_col(8'h40, 8'h42, 8'h40, 1'b0));
    send_col(band_col(8'h41, 8'h44, 8'h3f, 1'b0));
    send_col(band_col(8'h40, 8'h40, 8'h40, 1'b1));
    send_col(band_col(8'h00, 8'hff, 8'h00, 1'b1));

    cols_sent = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       amt = 8'd255;
        1:       amt = 8'd0;
        2:       amt = AmountReset;
        3:       amt = 8'd1;
        default: amt = 8'($urandom);
      endcase
      set_amount(amt);
      allow_gaps = (ph % 3 != 1);
      phase_end = (ph + 1) * ItemsRandom / NumPhases;
      while (cols_sent < phase_end) begin
        row_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                              : $urandom_range(3, 24);
        send_rand_row(row_len);
      end
    end

    drain();
    if (fail_cnt == 0 && pending == 0)
      $display("rgb_sharpen_filter_3x3 regression: pass");
    else
      $display("rgb_sharpen_filter_3x3 regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/rsf_pkg.sv
sv/rsf_in_if.sv
sv/rsf_out_if.sv
sv/rsf_cfg_if.sv
sv/rgb_sharpen_filter_3x3.sv
test/rsf_sharpen_checker.sv
test/tb_rgb_sharpen_filter_3x3.sv
